/* rtl/stid_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stid_pkg: shared codes for the sorted table
// Request and status encodings used by the table sequencer and its users.
// ---------------------------------------------------------------------------
package stid_pkg;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    localparam t_req REQ_INSERT = 2'd0;
    localparam t_req REQ_DELETE = 2'd1;
    localparam t_req REQ_DUMP   = 2'd2;
    localparam t_req REQ_NONE   = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

endpackage

/* rtl/sorted_table_insert_delete.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_table_insert_delete: ascending table of signed values
// Insert, delete-first-match and in-order dump over a table with one read and one write port.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_req_valid / o_req_ready with i_req_type and i_value.
//   Results leave on o_res_valid / i_res_ready, one field per port.
//   Insert and delete give one result with o_last set; a dump gives one
//   result per stored entry, o_last on the final one, or a single result
//   with status empty when the table holds nothing. Request type 3 is dropped.
//   The block takes one request at a time: o_req_ready is high only while
//   the sequencer is idle, and it stays low until the last result is taken.
//   Every step goes through the one table read port and one compare unit;
//   each visited entry takes a read state, then a compare and write-back state.
//   Work done for each accepted request:
//     insert: walks down past every entry at or above the new value,
//             then writes it into the freed slot (slot zero needs no compare)
//     delete: visits every stored entry, shifting those after the match down
//     dump:   reads, captures and hands out each entry in turn
//   Rejected requests (full, empty) go straight to the result state; a dropped one stays idle.
//   A stalled receiver holds the result register and the sequencer.
//   Reset empties the table at once (count to zero); no clearing pass.
// ---------------------------------------------------------------------------
module sorted_table_insert_delete
    import stid_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  logic [1:0]                 i_req_type,
    input  logic signed [DATA_W-1:0]   i_value,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [1:0]                 o_status,
    output logic signed [DATA_W-1:0]   o_entry_value,
    output logic [POS_W-1:0]           o_position,
    output logic [COUNT_W-1:0]         o_count_after,
    output logic                       o_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS_RD = 3'd1;
    localparam logic [2:0] S_INS_EV = 3'd2;
    localparam logic [2:0] S_DEL_RD = 3'd3;
    localparam logic [2:0] S_DEL_EV = 3'd4;
    localparam logic [2:0] S_DMP_RD = 3'd5;
    localparam logic [2:0] S_DMP_EV = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic signed [DATA_W-1:0] r_mem [CAPACITY];
    logic signed [DATA_W-1:0] r_rd_data;

    logic [2:0]               r_state, n_state;
    logic [IW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_idx, n_idx;
    logic [IW-1:0]            r_pos, n_pos;
    logic                     r_found, n_found;
    logic signed [DATA_W-1:0] r_val, n_val;

    logic                     r_res_valid, n_res_valid;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_entry, n_entry;
    logic [IW-1:0]            r_opos, n_opos;
    logic [IW-1:0]            r_ocnt, n_ocnt;
    logic                     r_last, n_last;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [IW-1:0]            idx_m1;
    logic [IW-1:0]            idx_p1;

    assign idx_m1 = r_idx - IW'(1);
    assign idx_p1 = r_idx + IW'(1);

    // table storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_found     = r_found;
        n_val       = r_val;
        n_res_valid = r_res_valid;
        n_status    = r_status;
        n_entry     = r_entry;
        n_opos      = r_opos;
        n_ocnt      = r_ocnt;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[AW-1:0];
        mem_wdata   = r_rd_data;
        mem_raddr   = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_val   = i_value;
                    n_found = 1'b0;
                    n_status = ST_OK;
                    n_entry  = '0;
                    n_opos   = '0;
                    n_ocnt   = r_count;
                    n_last   = 1'b1;
                    unique case (i_req_type)
                        REQ_INSERT: begin
                            if (r_count == IW'(CAPACITY)) begin
                                n_status    = ST_FULL;
                                n_res_valid = 1'b1;
                                n_state     = S_OUT;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        REQ_DELETE, REQ_DUMP: begin
                            if (r_count == '0) begin
                                n_status    = ST_EMPTY;
                                n_res_valid = 1'b1;
                                n_state     = S_OUT;
                            end else begin
                                n_idx   = '0;
                                n_state = (i_req_type == REQ_DELETE) ? S_DEL_RD : S_DMP_RD;
                            end
                        end
                        default: begin
                            // unused request type: drop it
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_idx == '0) begin
                    mem_we      = 1'b1;
                    mem_wdata   = r_val;
                    n_count     = r_count + IW'(1);
                    n_opos      = '0;
                    n_ocnt      = r_count + IW'(1);
                    n_res_valid = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    mem_raddr = idx_m1[AW-1:0];
                    n_state   = S_INS_EV;
                end
            end
            S_INS_EV: begin
                mem_we = 1'b1;
                if (r_rd_data >= r_val) begin
                    // move the entry up one slot and keep walking down
                    mem_wdata = r_rd_data;
                    n_idx     = idx_m1;
                    n_state   = S_INS_RD;
                end else begin
                    mem_wdata   = r_val;
                    n_count     = r_count + IW'(1);
                    n_opos      = r_idx;
                    n_ocnt      = r_count + IW'(1);
                    n_res_valid = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_DEL_RD: begin
                if (r_idx == r_count) begin
                    if (r_found) begin
                        n_count  = r_count - IW'(1);
                        n_ocnt   = r_count - IW'(1);
                        n_opos   = r_pos;
                        n_status = ST_OK;
                    end else begin
                        n_ocnt   = r_count;
                        n_opos   = '0;
                        n_status = ST_NOT_FOUND;
                    end
                    n_res_valid = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_state = S_DEL_EV;
                end
            end
            S_DEL_EV: begin
                if (r_found) begin
                    // close the gap behind the removed entry
                    mem_we    = 1'b1;
                    mem_waddr = idx_m1[AW-1:0];
                    mem_wdata = r_rd_data;
                end else if (r_rd_data == r_val) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                end
                n_idx   = idx_p1;
                n_state = S_DEL_RD;
            end
            S_DMP_RD: begin
                n_state = S_DMP_EV;
            end
            S_DMP_EV: begin
                n_entry     = r_rd_data;
                n_opos      = r_idx;
                n_ocnt      = r_count;
                n_last      = (idx_p1 == r_count);
                n_status    = ST_OK;
                n_res_valid = 1'b1;
                n_idx       = idx_p1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_res_valid = 1'b0;
                    n_state     = r_last ? S_IDLE : S_DMP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_val    <= n_val;
        r_status <= n_status;
        r_entry  <= n_entry;
        r_opos   <= n_opos;
        r_ocnt   <= n_ocnt;
        r_last   <= n_last;
    end

    assign o_req_ready   = (r_state == S_IDLE);
    assign o_res_valid   = r_res_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_entry;
    assign o_position    = POS_W'(r_opos);
    assign o_count_after = COUNT_W'(r_ocnt);
    assign o_last        = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) && (n_count != r_count) |->
            (n_count == r_count + IW'(1)) || (n_count == r_count - IW'(1)))
        else $error("entry count moved by more than one");

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_status != ST_OK) |-> o_last)
        else $error("failed request result not marked last");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !o_req_ready)
        else $error("request taken while a result is pending");

endmodule
